// ----- hdl/dtse_pkg.sv -----
package dtse_pkg;

	localparam int unsigned ELAPSED_W = 32;
	localparam int unsigned SMOOTH_W = 48;
	localparam int unsigned CFG_IDX_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN = 8'd1;

	localparam logic [15:0] SMOOTHING_RESET = 16'd58982;
	localparam logic [15:0] GAIN_RESET = 16'd1024;

	typedef struct packed {
		logic signed [ELAPSED_W-1:0] elapsed;
		logic signed [SMOOTH_W-1:0] smoothed;
	} win_entry_t;

	typedef struct packed {
		logic start;
		logic signed [63:0] a;
		logic signed [63:0] b;
	} mul_req_t;

endpackage

// ----- hdl/dtse_window.sv -----
module dtse_window import dtse_pkg::*; #(
	parameter int unsigned DEPTH = 20
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] waddr,
	input win_entry_t wdata,
	input logic re,
	input logic [$clog2(DEPTH)-1:0] raddr,
	output win_entry_t rdata
);

	win_entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hdl/dtse_mul.sv -----
module dtse_mul import dtse_pkg::*; (
	input logic clk,
	input logic arst_n,
	input mul_req_t req,
	output logic done,
	output logic signed [127:0] p
);

	logic [63:0] ua_q, ub_q;
	logic neg_q;
	logic [2:0] cnt_q;
	logic [1:0] k_s1;
	logic [63:0] pp_s1;
	logic [127:0] acc_q;
	logic [1:0] k;
	logic [127:0] pp_shift;

	// partial products of 32-bit halves, k[1] picks a half, k[0] picks b half
	assign k = 2'(cnt_q - 3'd1);

	always_comb begin
		case (k_s1)
			2'd0: pp_shift = {64'd0, pp_s1};
			2'd1, 2'd2: pp_shift = {32'd0, pp_s1, 32'd0};
			default: pp_shift = {pp_s1, 64'd0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (req.start) begin
				cnt_q <= 3'd1;
			end else if (cnt_q != 3'd0) begin
				if (cnt_q == 3'd5) begin
					cnt_q <= 3'd0;
					done <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			ua_q <= req.a[63] ? 64'(-req.a) : req.a;
			ub_q <= req.b[63] ? 64'(-req.b) : req.b;
			neg_q <= req.a[63] ^ req.b[63];
			acc_q <= '0;
		end else begin
			if (cnt_q >= 3'd1 && cnt_q <= 3'd4) begin
				pp_s1 <= (k[1] ? ua_q[63:32] : ua_q[31:0]) * (k[0] ? ub_q[63:32] : ub_q[31:0]);
				k_s1 <= k;
			end
			if (cnt_q >= 3'd2) begin
				acc_q <= acc_q + pp_shift;
			end
		end
	end

	assign p = neg_q ? -$signed(acc_q) : $signed(acc_q);

endmodule

// ----- hdl/delay_trendline_slope_estimator.sv -----
// Delay trendline slope estimator. Each delay sample transaction updates the accumulated and
// smoothed delay, stores (elapsed time, smoothed delay) in a window memory and, once the window
// has filled, refits the least-squares slope. Each sample returns gain * slope / 256, rounded.
// One shared 64x64 multiplier, built from four 32x32 partial products, does the smoothing,
// window and cross products. A filled sample takes two window products per entry, two cross
// products, then a 33-step restoring divider. One sample is in work at a time; a finished
// result waits in the output register while the next sample is already taken.
module delay_trendline_slope_estimator import dtse_pkg::*; #(
	parameter int unsigned WINDOW_DEPTH = 20
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic signed [23:0] receive_delta,
	input logic signed [23:0] send_delta,
	input logic [47:0] arrival_time,
	output logic out_valid,
	input logic out_stall,
	output logic signed [31:0] scaled_slope,
	output logic window_full,
	input logic cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [15:0] cfg_data
);

	localparam int unsigned AW = $clog2(WINDOW_DEPTH);
	localparam int unsigned NX_W = ELAPSED_W + AW + 1;
	localparam int unsigned SX_W = ELAPSED_W + AW + 1;
	localparam int unsigned SY_W = SMOOTH_W + AW + 1;
	localparam logic [AW-1:0] LAST = AW'(WINDOW_DEPTH - 1);

	typedef enum logic [20:0] {
		S_IDLE = 21'h000001, S_SM1 = 21'h000002, S_SM1W = 21'h000004,
		S_SM2 = 21'h000008, S_SM2W = 21'h000010, S_WR = 21'h000020,
		S_RD = 21'h000040, S_XY = 21'h000080, S_XYW = 21'h000100,
		S_XX = 21'h000200, S_XXW = 21'h000400, S_SXY = 21'h000800,
		S_SXYW = 21'h001000, S_SXX = 21'h002000, S_SXXW = 21'h004000,
		S_DEN = 21'h008000, S_DIVCHK = 21'h010000, S_DIV = 21'h020000,
		S_SLOPE = 21'h040000, S_GMUL = 21'h080000, S_OUT = 21'h100000
	} state_t;

	state_t state_q;
	logic [15:0] coef_q, gain_q;
	logic [47:0] first_q;
	logic first_seen_q;
	logic signed [47:0] acc_q, smooth_q;
	logic signed [31:0] elapsed_q, slope_q;
	logic [AW-1:0] wp_q, ri_q;
	logic filled_q;
	logic signed [SX_W-1:0] sx_q;
	logic signed [SY_W-1:0] sy_q;
	logic signed [127:0] p1_q, sxy_q, sxx_q, num_q, den_q;
	logic [127:0] n_q, d2_q, r_q;
	logic [159:0] dsh_q;
	logic [32:0] q_q;
	logic [5:0] cnt_q;
	logic neg_q;
	logic signed [48:0] gp_q;
	logic out_valid_q, full_q;
	logic signed [31:0] scaled_q;

	mul_req_t mreq;
	logic mdone;
	logic signed [127:0] mp;
	logic win_we, win_re;
	win_entry_t win_rd;

	logic in_acc;
	logic signed [48:0] acc_sum, el_diff;
	logic [47:0] first_eff;
	logic signed [127:0] sm_sum;
	logic signed [NX_W-1:0] nx;
	logic [127:0] mag;
	logic [32:0] lim;
	logic signed [49:0] g_rnd;
	logic signed [41:0] g_shr;

	assign in_stall = (state_q != S_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign scaled_slope = scaled_q;
	assign window_full = full_q;

	assign acc_sum = 49'(acc_q) + 49'(receive_delta) - 49'(send_delta);
	assign first_eff = first_seen_q ? first_q : arrival_time;
	assign el_diff = $signed({1'b0, arrival_time}) - $signed({1'b0, first_eff});
	assign sm_sum = p1_q + mp + 128'sd32768;
	assign nx = NX_W'(win_rd.elapsed) * $signed(NX_W'(WINDOW_DEPTH));
	assign mag = num_q[127] ? 128'(-num_q) : num_q;
	assign lim = neg_q ? 33'h080000000 : 33'h07fffffff;
	assign g_rnd = 50'(gp_q) + 50'sd128;
	assign g_shr = 42'(g_rnd >>> 8);

	dtse_window #(.DEPTH(WINDOW_DEPTH)) u_window (
		.clk(clk),
		.we(win_we),
		.waddr(wp_q),
		.wdata({elapsed_q, smooth_q}),
		.re(win_re),
		.raddr(ri_q),
		.rdata(win_rd)
	);

	dtse_mul u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.req(mreq),
		.done(mdone),
		.p(mp)
	);

	assign win_we = (state_q == S_WR);
	assign win_re = (state_q == S_RD);

	always_comb begin
		mreq.start = 1'b0;
		mreq.a = '0;
		mreq.b = '0;
		unique case (state_q)
			S_SM1: begin
				mreq.start = 1'b1;
				mreq.a = 64'({1'b0, coef_q});
				mreq.b = 64'(smooth_q);
			end
			S_SM2: begin
				mreq.start = 1'b1;
				mreq.a = 64'(18'sh10000 - $signed({2'b0, coef_q}));
				mreq.b = 64'(acc_q);
			end
			S_XY: begin
				mreq.start = 1'b1;
				mreq.a = 64'(nx);
				mreq.b = 64'(win_rd.smoothed);
			end
			S_XX: begin
				mreq.start = 1'b1;
				mreq.a = 64'(nx);
				mreq.b = 64'(win_rd.elapsed);
			end
			S_SXY: begin
				mreq.start = 1'b1;
				mreq.a = 64'(sx_q);
				mreq.b = 64'(sy_q);
			end
			S_SXX: begin
				mreq.start = 1'b1;
				mreq.a = 64'(sx_q);
				mreq.b = 64'(sx_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			coef_q <= SMOOTHING_RESET;
			gain_q <= GAIN_RESET;
			first_q <= '0;
			first_seen_q <= 1'b0;
			acc_q <= '0;
			smooth_q <= '0;
			wp_q <= '0;
			filled_q <= 1'b0;
			slope_q <= '0;
			out_valid_q <= 1'b0;
			ri_q <= '0;
			cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_SMOOTHING: coef_q <= cfg_data;
					REG_GAIN: gain_q <= cfg_data;
					default: ;
				endcase
			end
			// the output stage reloads the register itself
			if (out_valid_q && !out_stall && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: if (in_acc) begin
					first_q <= first_eff;
					first_seen_q <= 1'b1;
					if (acc_sum > 49'sh00007fffffffffff) acc_q <= 48'sh7fffffffffff;
					else if (acc_sum < -49'sh000800000000000) acc_q <= 48'sh800000000000;
					else acc_q <= 48'(acc_sum);
					if (el_diff > 49'sh0007fffffff) elapsed_q <= 32'sh7fffffff;
					else if (el_diff < -49'sh00080000000) elapsed_q <= 32'sh80000000;
					else elapsed_q <= 32'(el_diff);
					state_q <= S_SM1;
				end
				S_SM1: state_q <= S_SM1W;
				S_SM1W: if (mdone) begin
					p1_q <= mp;
					state_q <= S_SM2;
				end
				S_SM2: state_q <= S_SM2W;
				S_SM2W: if (mdone) begin
					smooth_q <= sm_sum[63:16];
					state_q <= S_WR;
				end
				S_WR: begin
					wp_q <= (wp_q == LAST) ? '0 : wp_q + AW'(1);
					if (filled_q || wp_q == LAST) begin
						filled_q <= 1'b1;
						ri_q <= '0;
						sx_q <= '0;
						sy_q <= '0;
						sxy_q <= '0;
						sxx_q <= '0;
						state_q <= S_RD;
					end else begin
						state_q <= S_GMUL;
					end
				end
				S_RD: state_q <= S_XY;
				S_XY: begin
					sx_q <= sx_q + SX_W'(win_rd.elapsed);
					sy_q <= sy_q + SY_W'(win_rd.smoothed);
					state_q <= S_XYW;
				end
				S_XYW: if (mdone) begin
					sxy_q <= sxy_q + mp;
					state_q <= S_XX;
				end
				S_XX: state_q <= S_XXW;
				S_XXW: if (mdone) begin
					sxx_q <= sxx_q + mp;
					if (ri_q == LAST) begin
						state_q <= S_SXY;
					end else begin
						ri_q <= ri_q + AW'(1);
						state_q <= S_RD;
					end
				end
				S_SXY: state_q <= S_SXYW;
				S_SXYW: if (mdone) begin
					num_q <= sxy_q - mp;
					state_q <= S_SXX;
				end
				S_SXX: state_q <= S_SXXW;
				S_SXXW: if (mdone) begin
					den_q <= sxx_q - mp;
					state_q <= S_DEN;
				end
				S_DEN: begin
					// flat or degenerate window gives a zero slope
					if (den_q == '0 || den_q[127]) begin
						slope_q <= '0;
						state_q <= S_GMUL;
					end else begin
						neg_q <= num_q[127];
						n_q <= (mag << 9) + den_q;
						d2_q <= den_q << 1;
						state_q <= S_DIVCHK;
					end
				end
				S_DIVCHK: begin
					r_q <= n_q;
					dsh_q <= {d2_q, 32'd0};
					q_q <= '0;
					cnt_q <= '0;
					// quotient of 2^33 or more saturates without dividing
					if ({34'd0, n_q} >= {1'b0, d2_q, 33'd0}) begin
						slope_q <= neg_q ? 32'sh80000000 : 32'sh7fffffff;
						state_q <= S_GMUL;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if ({32'd0, r_q} >= dsh_q) begin
						r_q <= r_q - dsh_q[127:0];
						q_q <= {q_q[31:0], 1'b1};
					end else begin
						q_q <= {q_q[31:0], 1'b0};
					end
					dsh_q <= dsh_q >> 1;
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd32) state_q <= S_SLOPE;
				end
				S_SLOPE: begin
					if (q_q > lim) slope_q <= neg_q ? -$signed(lim[31:0]) : $signed(lim[31:0]);
					else slope_q <= neg_q ? -$signed(q_q[31:0]) : $signed(q_q[31:0]);
					state_q <= S_GMUL;
				end
				S_GMUL: begin
					gp_q <= $signed({1'b0, gain_q}) * slope_q;
					state_q <= S_OUT;
				end
				S_OUT: if (!out_valid_q || !out_stall) begin
					if (g_shr > 42'sh0007fffffff) scaled_q <= 32'sh7fffffff;
					else if (g_shr < -42'sh00080000000) scaled_q <= 32'sh80000000;
					else scaled_q <= 32'(g_shr);
					full_q <= filled_q;
					out_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_wp_range: assert property (@(posedge clk) disable iff (!arst_n) wp_q <= LAST)
		else $error("write pointer out of range");
	a_fit_filled: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD) |-> filled_q)
		else $error("window fit before window filled");
	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (state_q == S_SM1))
		else $error("accepted transaction did not start smoothing");
	a_mul_done: assert property (@(posedge clk) disable iff (!arst_n)
		mdone |-> (state_q == S_SM1W || state_q == S_SM2W || state_q == S_XYW ||
			state_q == S_XXW || state_q == S_SXYW || state_q == S_SXXW))
		else $error("multiplier finished outside a wait state");

endmodule

// ----- tb/tb_delay_trendline_slope_estimator.sv -----
`timescale 1ns / 100ps

module tb_delay_trendline_slope_estimator;
	import dtse_pkg::*;

	localparam int DEPTH = 20;
	localparam longint LIMIT = 2000000;
	localparam int DRAIN_CYCLES = 400;
	localparam int HOLD_CYCLES = 3000;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd5;
	localparam longint LIM48 = (longint'(1) <<< 47) - 1;
	localparam longint MAX32 = 64'sd2147483647;
	localparam longint MIN32 = -64'sd2147483648;

	typedef struct {
		logic signed [31:0] slope;
		bit full;
	} slope_res_t;

	typedef struct {
		logic signed [23:0] rd;
		logic signed [23:0] sd;
		logic [47:0] at;
		bit typed;
		logic signed [31:0] slope;
		bit full;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [23:0] receive_delta = '0;
	logic signed [23:0] send_delta = '0;
	logic [47:0] arrival_time = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] scaled_slope;
	logic window_full;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	delay_trendline_slope_estimator #(.WINDOW_DEPTH(DEPTH)) dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	int unsigned coef = SMOOTHING_RESET;
	int unsigned gain = GAIN_RESET;
	logic [47:0] t_first = '0;
	bit t_first_valid = 0;
	longint acc_dly = 0;
	longint smooth_dly = 0;
	int win_t[DEPTH];
	longint win_d[DEPTH];
	int wr_idx = 0;
	bit win_filled = 0;
	logic signed [31:0] fitted_slope = '0;

	slope_res_t expected_slopes[$];
	int errors = 0;
	longint cyc = 0;
	bit idle_on = 1;
	bit hold_req = 0;
	bit hold_done = 0;
	int stall_left = 0;

	function automatic logic signed [31:0] fit_window();
		longint sx, sy;
		logic signed [127:0] sxy, sxx, x, y, sx_w, sy_w, n_w, num, den;
		logic [127:0] mag, den_u, q, lim;
		bit neg;
		sx = 0;
		sy = 0;
		sxy = 0;
		sxx = 0;
		for (int i = 0; i < DEPTH; i++) begin
			x = win_t[i];
			y = win_d[i];
			sx += win_t[i];
			sy += win_d[i];
			sxy += x * y;
			sxx += x * x;
		end
		sx_w = sx;
		sy_w = sy;
		n_w = DEPTH;
		num = n_w * sxy - sx_w * sy_w;
		den = n_w * sxx - sx_w * sx_w;
		if (den <= 0)
			return '0;
		neg = num[127];
		mag = neg ? -num : num;
		den_u = den;
		q = ((mag << 9) + den_u) / (den_u << 1);
		lim = neg ? (128'd1 << 31) : (128'd1 << 31) - 1;
		if (q > lim)
			q = lim;
		return neg ? -q[31:0] : q[31:0];
	endfunction

	function automatic slope_res_t trend_predict(logic signed [23:0] rd, logic signed [23:0] sd,
			logic [47:0] at);
		longint delta, acc, sum, elapsed, scaled, c;
		slope_res_t r;
		delta = longint'(rd) - longint'(sd);
		c = coef;
		if (!t_first_valid) begin
			t_first = at;
			t_first_valid = 1;
		end
		acc = acc_dly + delta;
		if (acc > LIM48)
			acc = LIM48;
		if (acc < -LIM48 - 1)
			acc = -LIM48 - 1;
		acc_dly = acc;
		sum = c * smooth_dly + (65536 - c) * acc;
		smooth_dly = (sum + 32768) >>> 16;
		elapsed = longint'({16'd0, at}) - longint'({16'd0, t_first});
		if (elapsed > MAX32)
			elapsed = MAX32;
		if (elapsed < MIN32)
			elapsed = MIN32;
		win_t[wr_idx] = int'(elapsed);
		win_d[wr_idx] = smooth_dly;
		wr_idx++;
		if (wr_idx >= DEPTH) begin
			wr_idx = 0;
			win_filled = 1;
		end
		if (win_filled)
			fitted_slope = fit_window();
		scaled = (longint'(gain) * longint'(fitted_slope) + 128) >>> 8;
		if (scaled > MAX32)
			scaled = MAX32;
		if (scaled < MIN32)
			scaled = MIN32;
		r.slope = scaled[31:0];
		r.full = win_filled;
		return r;
	endfunction

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// receiver: random stall bursts plus one long hold-off
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (hold_req && !hold_done) begin
			hold_done = 1;
			stall_left = HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(0, 17);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		slope_res_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_slopes.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result slope=%0d full=%0b", scaled_slope, window_full);
			end else begin
				e = expected_slopes.pop_front();
				if (scaled_slope !== e.slope || window_full !== e.full) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp slope=%0d full=%0b, got slope=%0d full=%0b",
							e.slope, e.full, scaled_slope, window_full);
				end
			end
		end
	end

	task automatic send_sample(logic signed [23:0] rd, logic signed [23:0] sd, logic [47:0] at,
			bit typed, logic signed [31:0] t_slope, bit t_full);
		slope_res_t r;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		in_valid <= 1'b1;
		receive_delta <= rd;
		send_delta <= sd;
		arrival_time <= at;
		do @(posedge clk); while (in_stall);
		r = trend_predict(rd, sd, at);
		if (typed) begin
			r.slope = t_slope;
			r.full = t_full;
		end
		expected_slopes.push_back(r);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_SMOOTHING)
			coef = val;
		else if (idx == REG_GAIN)
			gain = val;
		@(posedge clk);
	endtask

	task automatic drain();
		while (expected_slopes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	dir_row_t dir_tab[25];

	initial begin
		logic [47:0] t_now;
		logic signed [23:0] rd, sd;
		int drift;

		for (int i = 0; i < DEPTH; i++) begin
			win_t[i] = 0;
			win_d[i] = 0;
		end
		// all arrivals equal: the window fills with a zero denominator
		dir_tab[0] = '{24'sh7FFFFF, 24'sh800000, 48'd1000, 1, 0, 0};
		dir_tab[1] = '{24'sh800000, 24'sh7FFFFF, 48'd1000, 1, 0, 0};
		dir_tab[2] = '{24'sh000000, 24'sh000000, 48'd1000, 1, 0, 0};
		dir_tab[3] = '{24'sh7FFFFF, 24'sh000000, 48'd1000, 1, 0, 0};
		dir_tab[4] = '{24'sh800000, 24'sh000000, 48'd1000, 1, 0, 0};
		dir_tab[5] = '{24'sh000000, 24'sh7FFFFF, 48'd1000, 1, 0, 0};
		dir_tab[6] = '{24'sh000000, 24'sh800000, 48'd1000, 1, 0, 0};
		dir_tab[7] = '{24'shFFFFFF, 24'sh000001, 48'd1000, 1, 0, 0};
		dir_tab[8] = '{24'sh7FFFFF, 24'sh800000, 48'd1000, 1, 0, 0};
		dir_tab[9] = '{24'sh7FFFFF, 24'sh800000, 48'd1000, 1, 0, 0};
		dir_tab[10] = '{24'sh555555, 24'shAAAAAA, 48'd1000, 1, 0, 0};
		dir_tab[11] = '{24'shAAAAAA, 24'sh555555, 48'd1000, 1, 0, 0};
		dir_tab[12] = '{24'sh000100, 24'sh000000, 48'd1000, 1, 0, 0};
		dir_tab[13] = '{24'sh000100, 24'sh000000, 48'd1000, 1, 0, 0};
		dir_tab[14] = '{24'sh000000, 24'sh000100, 48'd1000, 1, 0, 0};
		dir_tab[15] = '{24'sh7FFFFF, 24'sh7FFFFF, 48'd1000, 1, 0, 0};
		dir_tab[16] = '{24'sh800000, 24'sh800000, 48'd1000, 1, 0, 0};
		dir_tab[17] = '{24'sh123456, 24'sh000000, 48'd1000, 1, 0, 0};
		dir_tab[18] = '{24'sh000000, 24'sh654321, 48'd1000, 1, 0, 0};
		dir_tab[19] = '{24'sh7FFFFF, 24'sh800000, 48'd1000, 1, 0, 1};
		// arrival before the first one, and elapsed time past the 32-bit range
		dir_tab[20] = '{24'sh000200, 24'sh000000, 48'd0, 0, 0, 0};
		dir_tab[21] = '{24'sh000200, 24'sh000000, 48'hFFFF_FFFF_FFFF, 0, 0, 0};
		dir_tab[22] = '{24'sh800000, 24'sh7FFFFF, 48'h8000_0000_0000, 0, 0, 0};
		dir_tab[23] = '{24'sh000300, 24'sh000000, 48'd1500, 0, 0, 0};
		dir_tab[24] = '{24'sh000000, 24'sh000300, 48'd1020, 0, 0, 0};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i])
			send_sample(dir_tab[i].rd, dir_tab[i].sd, dir_tab[i].at, dir_tab[i].typed,
				dir_tab[i].slope, dir_tab[i].full);
		in_valid <= 1'b0;

		t_now = 48'd2000;
		for (int ph = 0; ph < 6; ph++) begin
			in_valid <= 1'b0;
			drain();
			case (ph)
				0: begin
					write_reg(REG_SMOOTHING, 16'd0);
					write_reg(REG_GAIN, 16'hFFFF);
				end
				1: begin
					write_reg(REG_SMOOTHING, 16'hFFFF);
					write_reg(REG_GAIN, 16'd0);
					hold_req = 1;
				end
				2: begin
					write_reg(REG_SMOOTHING, SMOOTHING_RESET);
					write_reg(REG_GAIN, GAIN_RESET);
					write_reg(REG_UNUSED, 16'hFFFF);
				end
				3: begin
					write_reg(REG_SMOOTHING, 16'($urandom));
					write_reg(REG_GAIN, 16'($urandom));
				end
				4: begin
					write_reg(REG_SMOOTHING, 16'd32768);
					write_reg(REG_GAIN, 16'd256);
				end
				default: begin
					write_reg(REG_SMOOTHING, 16'($urandom));
					write_reg(REG_GAIN, 16'($urandom_range(0, 4096)));
					idle_on = 0;
				end
			endcase
			drift = $urandom_range(0, 1200) - 600;
			for (int k = 0; k < 108; k++) begin
				if ($urandom_range(0, 9) == 0) begin
					// noise: full-range fields, arbitrary arrival
					send_sample(24'($urandom), 24'($urandom), {16'($urandom), 32'($urandom)},
						0, 0, 0);
				end else begin
					t_now = t_now + 48'($urandom_range(1, 60));
					sd = 24'($urandom_range(0, 40000));
					rd = sd + 24'(drift + $urandom_range(0, 400) - 200);
					send_sample(rd, sd, t_now, 0, 0, 0);
				end
			end
		end
		in_valid <= 1'b0;

		while (expected_slopes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && expected_slopes.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
